// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
// every use assumes clk and rst_n are visible in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define DLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DLD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/dld_pkg.sv -----
package dld_pkg;

  // string capacity and field widths
  localparam int MAX_LEN   = 64;
  localparam int SYMBOLS   = 256;
  localparam int CH_W      = 8;
  localparam int FUNC_W    = 2;
  localparam int DIST_W    = 8;
  localparam int DIST_MAX  = 2**DIST_W - 1;

  // derived widths
  localparam int LEN_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_LEN + 2);
  localparam int COST_W    = $clog2(2 * MAX_LEN + 1);
  localparam int SUM_W     = COST_W + 2;
  localparam int TBL_DEPTH = 2**(2 * LEN_W);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_SRC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TGT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CALC = 2'd2;

  // compute request toward the table engine
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] slen;
    logic [CNT_W-1:0] tlen;
  } dld_start_t;

  // byte buffer read addresses from the engine
  typedef struct packed {
    logic [LEN_W-1:0] src_addr;
    logic [LEN_W-1:0] tgt_addr;
  } dld_rd_t;

  // finished distance back to the top level
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
  } dld_done_t;

  // clamp a wide cost to the output field
  function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] v);
    if (v > SUM_W'(DIST_MAX)) return '1;
    return v[DIST_W-1:0];
  endfunction

endpackage

// ----- sv/dld_if.sv -----
// input item channel
interface dld_in_if;
  logic                      valid;
  logic                      ready;
  logic [dld_pkg::FUNC_W-1:0] func;
  logic [dld_pkg::CH_W-1:0]   ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

// result channel
interface dld_out_if;
  logic                       valid;
  logic                       ready;
  logic [dld_pkg::DIST_W-1:0] distance;
  logic                       overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ----- sv/dld_core.sv -----
`include "assert_macros.svh"

module dld_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dld_pkg::dld_start_t       start,
  output dld_pkg::dld_rd_t          rd,
  input  logic [dld_pkg::CH_W-1:0]  src_data,
  input  logic [dld_pkg::CH_W-1:0]  tgt_data,
  output dld_pkg::dld_done_t        done
);

  localparam int IDX_W  = dld_pkg::IDX_W;
  localparam int COST_W = dld_pkg::COST_W;
  localparam int SUM_W  = dld_pkg::SUM_W;
  localparam int LEN_W  = dld_pkg::LEN_W;
  localparam int CNT_W  = dld_pkg::CNT_W;
  localparam int CH_W   = dld_pkg::CH_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ROW  = 7'b0000010,
    S_ROWD = 7'b0000100,
    S_TGT  = 7'b0001000,
    S_LS   = 7'b0010000,
    S_CELL = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // per-computation registers
  logic [CNT_W-1:0]  slen_r, tlen_r;
  logic [COST_W-1:0] inf_r;
  logic [IDX_W-1:0]  r_r, c_r, l_r;
  logic [CH_W-1:0]   sc_r, tc_r;
  logic [COST_W-1:0] left_r, diag_r;
  logic [SUM_W-1:0]  gap_r;

  // last-seen row table, valid bits cleared at each compute
  logic [IDX_W-1:0]  ls_mem [dld_pkg::SYMBOLS];
  logic [dld_pkg::SYMBOLS-1:0] ls_valid_r;
  logic [IDX_W-1:0]  ls_q;
  logic              lsv_q;

  // inner cost table, rows and columns from two upward
  logic [COST_W-1:0] cost_mem [dld_pkg::TBL_DEPTH];
  logic [COST_W-1:0] mem_a_q, mem_b_q, virt_a_q, virt_b_q;
  logic              use_a_q, use_b_q;

  logic                      done_valid_r;
  logic [dld_pkg::DIST_W-1:0] done_dist_r;

  logic              last_col, row_end, same;
  logic              cell_ok, trans_ok;
  logic [IDX_W-1:0]  k_eff;
  logic [COST_W:0]   src_a, src_b;
  logic [COST_W-1:0] up_v, kl_v;
  logic [SUM_W-1:0]  cand_up, cand_left, cand_diag, cand_tr, min_a, min_b, best_w;

  // table index of an inner cell
  function automatic logic [2*LEN_W-1:0] tbl_idx(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] ar;
    logic [IDX_W-1:0] br;
    ar = a - IDX_W'(2);
    br = b - IDX_W'(2);
    return {ar[LEN_W-1:0], br[LEN_W-1:0]};
  endfunction

  // guard and first row and column are implied, everything else lives in memory
  function automatic logic [COST_W:0] cost_src(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b,
                                               input logic [COST_W-1:0] inf);
    logic [IDX_W-1:0] am1;
    logic [IDX_W-1:0] bm1;
    am1 = a - IDX_W'(1);
    bm1 = b - IDX_W'(1);
    if (a == '0 || b == '0) return {1'b0, inf};
    if (a == IDX_W'(1)) return {1'b0, COST_W'(bm1)};
    if (b == IDX_W'(1)) return {1'b0, COST_W'(am1)};
    return {1'b1, {COST_W{1'b0}}};
  endfunction

  assign last_col = (c_r == IDX_W'(tlen_r));
  assign row_end  = (r_r == IDX_W'(slen_r));
  assign same     = (sc_r == tc_r);
  assign k_eff    = lsv_q ? ls_q : '0;

  // cell position checks
  assign cell_ok  = c_r != '0 && c_r <= IDX_W'(tlen_r) && r_r != '0 && r_r <= IDX_W'(slen_r);
  assign trans_ok = k_eff < r_r && l_r < c_r;

  assign rd.src_addr = LEN_W'(r_r - IDX_W'(1));
  assign rd.tgt_addr = LEN_W'(c_r - IDX_W'(1));

  assign src_a = cost_src(r_r, c_r + IDX_W'(1), inf_r);
  assign src_b = cost_src(k_eff, l_r, inf_r);

  // cell update: insert, delete, substitute, transpose
  always_comb begin
    up_v      = use_a_q ? mem_a_q : virt_a_q;
    kl_v      = use_b_q ? mem_b_q : virt_b_q;
    cand_up   = SUM_W'(up_v) + SUM_W'(1);
    cand_left = SUM_W'(left_r) + SUM_W'(1);
    cand_diag = SUM_W'(diag_r) + SUM_W'(!same);
    cand_tr   = SUM_W'(kl_v) + gap_r;
    min_a     = (cand_up < cand_left) ? cand_up : cand_left;
    min_b     = (cand_diag < cand_tr) ? cand_diag : cand_tr;
    best_w    = (min_a < min_b) ? min_a : min_b;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start.valid && start.slen != '0 && start.tlen != '0) state_nxt = S_ROW;
      end
      S_ROW:  state_nxt = S_ROWD;
      S_ROWD: state_nxt = S_TGT;
      S_TGT:  state_nxt = S_LS;
      S_LS:   state_nxt = S_CELL;
      S_CELL: state_nxt = S_UPD;
      S_UPD: begin
        if (!last_col) state_nxt = S_TGT;
        else if (row_end) state_nxt = S_IDLE;
        else state_nxt = S_ROW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ls_valid_r   <= '0;
      done_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      done_valid_r <= (state_r == S_IDLE && start.valid &&
                       (start.slen == '0 || start.tlen == '0)) ||
                      (state_r == S_UPD && last_col && row_end);
      if (state_r == S_IDLE && start.valid) ls_valid_r <= '0;
      if (state_r == S_UPD && last_col) ls_valid_r[sc_r] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start.valid) begin
          slen_r <= start.slen;
          tlen_r <= start.tlen;
          inf_r  <= COST_W'(start.slen) + COST_W'(start.tlen);
          r_r    <= IDX_W'(1);
          if (start.slen == '0) done_dist_r <= dld_pkg::sat_dist(SUM_W'(start.tlen));
          else done_dist_r <= dld_pkg::sat_dist(SUM_W'(start.slen));
        end
      end
      S_ROW: ;
      S_ROWD: begin
        sc_r   <= src_data;
        c_r    <= IDX_W'(1);
        l_r    <= '0;
        diag_r <= COST_W'(r_r - IDX_W'(1));
        left_r <= COST_W'(r_r);
      end
      S_TGT: ;
      S_LS: begin
        tc_r  <= tgt_data;
        lsv_q <= ls_valid_r[tgt_data];
      end
      S_CELL: begin
        {use_a_q, virt_a_q} <= src_a;
        {use_b_q, virt_b_q} <= src_b;
        gap_r <= SUM_W'(r_r - k_eff - IDX_W'(1)) + SUM_W'(c_r - l_r);
      end
      S_UPD: begin
        diag_r <= up_v;
        left_r <= best_w[COST_W-1:0];
        if (same) l_r <= c_r;
        if (last_col) begin
          r_r <= r_r + IDX_W'(1);
          if (row_end) done_dist_r <= dld_pkg::sat_dist(best_w);
        end else begin
          c_r <= c_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // last-seen memory
  always_ff @(posedge clk) begin
    if (state_r == S_LS) ls_q <= ls_mem[tgt_data];
    if (state_r == S_UPD && last_col) ls_mem[sc_r] <= r_r;
  end

  // cost memory: two reads, one write
  always_ff @(posedge clk) begin
    if (state_r == S_CELL) begin
      mem_a_q <= cost_mem[tbl_idx(r_r, c_r + IDX_W'(1))];
      mem_b_q <= cost_mem[tbl_idx(k_eff, l_r)];
    end
    if (state_r == S_UPD)
      cost_mem[tbl_idx(r_r + IDX_W'(1), c_r + IDX_W'(1))] <= best_w[COST_W-1:0];
  end

  assign done.valid    = done_valid_r;
  assign done.distance = done_dist_r;

  // checks
  `DLD_ASSERT(a_start_idle, start.valid |-> state_r == S_IDLE, "compute started while busy")
  `DLD_ASSERT(a_cell_range, state_r == S_CELL |-> cell_ok, "cell outside table")
  `DLD_ASSERT(a_trans_prior, state_r == S_CELL |-> trans_ok, "transposition cell not earlier")
  `DLD_NEVER(a_done_busy, done_valid_r && state_r != S_IDLE, "result while table walk runs")

endmodule

// ----- sv/damerau_levenshtein_distance.sv -----
// Unrestricted Damerau-Levenshtein distance between two byte strings.
// in_chan carries func and ch: func 0 appends ch to the source string,
// func 1 appends ch to the target string, func 2 computes the distance,
// func 3 is ignored. Each string holds up to 64 bytes; further bytes are
// dropped and reported through overflow with the next result.
// out_chan carries one result (distance, overflow) per compute transfer.
// Appends are accepted whenever in_chan.ready is high. With both strings
// nonempty a compute walks the table row by row, each cell in four steps
// on the single cost memory (target byte read, last-seen lookup, two-port
// cell read, write back); otherwise the distance is the larger length.
// in_chan.ready is low from the compute transfer until the result has been
// taken; a stalled receiver simply holds the result in the output register.
// After the result both strings and the overflow flag are empty again.
// Reset (rst_n low, synchronous) empties both strings, clears overflow
// and returns to accepting items; no clearing pass is needed.
module damerau_levenshtein_distance (
  input  logic      clk,
  input  logic      rst_n,
  dld_in_if.sink    in_chan,
  dld_out_if.source out_chan
);

  localparam int CNT_W = dld_pkg::CNT_W;
  localparam int LEN_W = dld_pkg::LEN_W;
  localparam int CH_W  = dld_pkg::CH_W;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [CH_W-1:0]  src_mem [dld_pkg::MAX_LEN];
  logic [CH_W-1:0]  tgt_mem [dld_pkg::MAX_LEN];
  logic [CH_W-1:0]  src_q, tgt_q;
  logic [CNT_W-1:0] scnt_r, tcnt_r;
  logic             drop_r, ovf_r;
  logic [dld_pkg::DIST_W-1:0] dist_r;

  logic               in_xfer, src_full, tgt_full;
  logic               wr_src, wr_tgt;
  dld_pkg::dld_start_t start;
  dld_pkg::dld_rd_t    rd;
  dld_pkg::dld_done_t  done;

  assign in_chan.ready = (state_r == T_IDLE);
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign src_full = (scnt_r == CNT_W'(dld_pkg::MAX_LEN));
  assign tgt_full = (tcnt_r == CNT_W'(dld_pkg::MAX_LEN));
  assign wr_src   = in_xfer && in_chan.func == dld_pkg::FUNC_SRC && !src_full;
  assign wr_tgt   = in_xfer && in_chan.func == dld_pkg::FUNC_TGT && !tgt_full;

  assign start.valid = in_xfer && in_chan.func == dld_pkg::FUNC_CALC;
  assign start.slen  = scnt_r;
  assign start.tlen  = tcnt_r;

  // table engine
  dld_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .rd       (rd),
    .src_data (src_q),
    .tgt_data (tgt_q),
    .done     (done)
  );

  // string buffers
  always_ff @(posedge clk) begin
    if (wr_src) src_mem[scnt_r[LEN_W-1:0]] <= in_chan.ch;
    if (wr_tgt) tgt_mem[tcnt_r[LEN_W-1:0]] <= in_chan.ch;
    src_q <= src_mem[rd.src_addr];
    tgt_q <= tgt_mem[rd.tgt_addr];
  end

  // item sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (start.valid) state_nxt = T_BUSY;
      T_BUSY: if (done.valid) state_nxt = T_OUT;
      T_OUT:  if (out_chan.ready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // counts and dropped flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      scnt_r  <= '0;
      tcnt_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        unique case (in_chan.func)
          dld_pkg::FUNC_SRC: begin
            if (src_full) drop_r <= 1'b1;
            else scnt_r <= scnt_r + CNT_W'(1);
          end
          dld_pkg::FUNC_TGT: begin
            if (tgt_full) drop_r <= 1'b1;
            else tcnt_r <= tcnt_r + CNT_W'(1);
          end
          default: ;
        endcase
      end
      if (state_r == T_BUSY && done.valid) begin
        scnt_r <= '0;
        tcnt_r <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == T_BUSY && done.valid) begin
      dist_r <= done.distance;
      ovf_r  <= drop_r;
    end
  end

  assign out_chan.valid    = (state_r == T_OUT);
  assign out_chan.distance = dist_r;
  assign out_chan.overflow = ovf_r;

endmodule
